### sv/vmt_pkg.sv
// Package for the 4x4 vertex transform engine.
// Holds default widths, request codes and matrix geometry; no dependencies.
`timescale 1ns / 1ps

package vmt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VEC_LEN  = 4;
    localparam int NUM_ELEM = VEC_LEN * VEC_LEN;
    localparam int IDX_W    = $clog2(NUM_ELEM);

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_XFORM = 1'b1
    } req_type_t;

endpackage

### sv/vmt_matrix_store.sv
// Matrix register file: sixteen row-major elements, identity after reset.
// Written one element per load word; depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_matrix_store #(
    parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            wr_en,
    input  logic [vmt_pkg::IDX_W-1:0]                       wr_index,
    input  logic [DATA_WIDTH-1:0]                           wr_value,
    output logic [vmt_pkg::NUM_ELEM-1:0][DATA_WIDTH-1:0]    matrix
);

    localparam logic [DATA_WIDTH-1:0] ONE_VAL =
        {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [vmt_pkg::NUM_ELEM-1:0][DATA_WIDTH-1:0] elem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vmt_pkg::NUM_ELEM; i++)
            begin
                elem_reg[i] <= ((i / vmt_pkg::VEC_LEN) == (i % vmt_pkg::VEC_LEN))
                               ? ONE_VAL : '0;
            end
        end
        else if (wr_en)
        begin
            elem_reg[wr_index] <= wr_value;
        end
    end

    assign matrix = elem_reg;

endmodule

### sv/vmt_mult_array.sv
// Input vector register and the sixteen-product multiply stage.
// Products are shifted right by the fraction width; depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_mult_array #(
    parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vmt_pkg::FRAC_BITS_DEF,
    localparam int PROD_W    = 2 * DATA_WIDTH - FRAC_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_stall,
    input  logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]     vec,
    input  logic [vmt_pkg::NUM_ELEM-1:0][DATA_WIDTH-1:0]    matrix,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic [vmt_pkg::NUM_ELEM-1:0][PROD_W-1:0]        prod
);

    logic                                         v1_reg;
    logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]  vec_reg;
    logic                                         v2_reg;
    logic [vmt_pkg::NUM_ELEM-1:0][PROD_W-1:0]     prod_reg;
    logic [vmt_pkg::NUM_ELEM-1:0][PROD_W-1:0]     prod_next;
    logic                                         en1;
    logic                                         en2;

    assign en2      = !v2_reg || !out_stall;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_comb
    begin
        logic signed [2*DATA_WIDTH-1:0] full;
        full = '0;
        for (int i = 0; i < vmt_pkg::VEC_LEN; i++)
        begin
            for (int j = 0; j < vmt_pkg::VEC_LEN; j++)
            begin
                full = $signed(vec_reg[j]) * $signed(matrix[vmt_pkg::VEC_LEN*i+j]);
                prod_next[vmt_pkg::VEC_LEN*i+j] = full[2*DATA_WIDTH-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            vec_reg <= vec;
        end
        if (en2 && v1_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = v2_reg;
    assign prod      = prod_reg;

endmodule

### sv/vmt_accum_sat.sv
// Two-level adder tree per row with saturation into the output register.
// Takes the shifted products of vmt_mult_array; depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_accum_sat #(
    parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vmt_pkg::FRAC_BITS_DEF,
    localparam int PROD_W    = 2 * DATA_WIDTH - FRAC_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_stall,
    input  logic [vmt_pkg::NUM_ELEM-1:0][PROD_W-1:0]        prod,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]     result
);

    localparam int PART_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = SUM_W - DATA_WIDTH + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{EXT_W{1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{EXT_W{1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic                                          v3_reg;
    logic [vmt_pkg::VEC_LEN-1:0][1:0][PART_W-1:0]  part_reg;
    logic [vmt_pkg::VEC_LEN-1:0][1:0][PART_W-1:0]  part_next;
    logic                                          v4_reg;
    logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]   res_reg;
    logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]   res_next;
    logic                                          en3;
    logic                                          en4;

    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign in_stall = !en3;

    always_comb
    begin
        for (int i = 0; i < vmt_pkg::VEC_LEN; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                part_next[i][k] =
                    PART_W'($signed(prod[vmt_pkg::VEC_LEN*i+2*k]))
                    + PART_W'($signed(prod[vmt_pkg::VEC_LEN*i+2*k+1]));
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < vmt_pkg::VEC_LEN; i++)
        begin
            sum = SUM_W'($signed(part_reg[i][0])) + SUM_W'($signed(part_reg[i][1]));
            if (sum > SAT_HI)
            begin
                res_next[i] = SAT_HI[DATA_WIDTH-1:0];
            end
            else if (sum < SAT_LO)
            begin
                res_next[i] = SAT_LO[DATA_WIDTH-1:0];
            end
            else
            begin
                res_next[i] = sum[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                v3_reg <= in_valid;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            part_reg <= part_next;
        end
        if (en4 && v3_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign result    = res_reg;

endmodule

### sv/vector_matrix_transform_4x4.sv
// Top level of the 4x4 vertex transform engine in signed fixed point.
// Instantiates vmt_matrix_store, vmt_mult_array and vmt_accum_sat; uses vmt_pkg.
`timescale 1ns / 1ps

// The block takes one input word per clock unless in_stall is high and, with no stall at
// the output, gives one result word per clock. A load word writes one matrix element at its
// acceptance edge and gives no result; a transform word sees every load accepted before it
// and none after it. A transform result passes four register stages on its way to the
// outputs: vector register, sixteen parallel multipliers, a first adder level, then the
// final add with saturation into the output register. A stall at the output holds the
// occupied stages that cannot advance and stalls the input only once all four are occupied.

module vector_matrix_transform_4x4 #(
    parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [vmt_pkg::IDX_W-1:0]     element_index,
    input  logic signed [DATA_WIDTH-1:0]  element_value,
    input  logic signed [DATA_WIDTH-1:0]  vec_x,
    input  logic signed [DATA_WIDTH-1:0]  vec_y,
    input  logic signed [DATA_WIDTH-1:0]  vec_z,
    input  logic signed [DATA_WIDTH-1:0]  vec_w,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  out_x,
    output logic signed [DATA_WIDTH-1:0]  out_y,
    output logic signed [DATA_WIDTH-1:0]  out_z,
    output logic signed [DATA_WIDTH-1:0]  out_w
);

    localparam int PROD_W = 2 * DATA_WIDTH - FRAC_BITS;

    logic [vmt_pkg::NUM_ELEM-1:0][DATA_WIDTH-1:0] matrix;
    logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]  vec;
    logic [vmt_pkg::NUM_ELEM-1:0][PROD_W-1:0]     prod;
    logic [vmt_pkg::VEC_LEN-1:0][DATA_WIDTH-1:0]  result;
    logic                                         load_en;
    logic                                         xform_valid;
    logic                                         mul_stall;
    logic                                         prod_valid;
    logic                                         acc_stall;

    assign load_en     = in_valid && !mul_stall
                         && (req_type == vmt_pkg::REQ_LOAD);
    assign xform_valid = in_valid && (req_type == vmt_pkg::REQ_XFORM);
    assign in_stall    = mul_stall;

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;
    assign vec[3] = vec_w;

    vmt_matrix_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_en),
        .wr_index (element_index),
        .wr_value (element_value),
        .matrix   (matrix)
    );

    vmt_mult_array #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xform_valid),
        .in_stall  (mul_stall),
        .vec       (vec),
        .matrix    (matrix),
        .out_valid (prod_valid),
        .out_stall (acc_stall),
        .prod      (prod)
    );

    vmt_accum_sat #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_stall  (acc_stall),
        .prod      (prod),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign out_x = result[0];
    assign out_y = result[1];
    assign out_z = result[2];
    assign out_w = result[3];

endmodule

### tb/testbench.sv
// Self-checking testbench for vector_matrix_transform_4x4, the 4x4 fixed-point vertex transform.
// It depends on vmt_pkg and the RTL only. A built-in predictor supplies the expected results,
// and a checker compares every result word with them under random idling and stalls.
`timescale 1ns / 1ps

module testbench;

    localparam int DW = vmt_pkg::DATA_WIDTH_DEF;
    localparam int FB = vmt_pkg::FRAC_BITS_DEF;
    localparam int VL = vmt_pkg::VEC_LEN;
    localparam int NE = vmt_pkg::NUM_ELEM;
    localparam int IW = vmt_pkg::IDX_W;
    localparam longint SAT_HI = (longint'(1) << (DW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam logic signed [DW-1:0] Q_MAX = SAT_HI[DW-1:0];
    localparam logic signed [DW-1:0] Q_MIN = SAT_LO[DW-1:0];
    localparam logic signed [DW-1:0] Q_ONE = DW'(1) << FB;
    localparam int HOLD_LEN = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 30;

    typedef logic [VL-1:0][DW-1:0] quad_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    vmt_pkg::req_type_t   req_type = vmt_pkg::REQ_LOAD;
    logic [IW-1:0]        element_index = '0;
    logic signed [DW-1:0] element_value = '0;
    logic signed [DW-1:0] vec_x = '0;
    logic signed [DW-1:0] vec_y = '0;
    logic signed [DW-1:0] vec_z = '0;
    logic signed [DW-1:0] vec_w = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic signed [DW-1:0] out_z;
    logic signed [DW-1:0] out_w;

    logic signed [DW-1:0] matrix_model [NE];
    quad_t                expected_vertices [$];
    int unsigned          error_count = 0;
    int unsigned          cycle_count = 0;
    bit                   idle_enable = 1'b0;
    bit                   stall_enable = 1'b0;
    bit                   hold_req = 1'b0;
    int unsigned          hold_count = 0;
    int unsigned          burst_left = 0;
    string                field_names [VL] = '{"out_x", "out_y", "out_z", "out_w"};

    vector_matrix_transform_4x4 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .element_index (element_index),
        .element_value (element_value),
        .vec_x         (vec_x),
        .vec_y         (vec_y),
        .vec_z         (vec_z),
        .vec_w         (vec_w),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_w         (out_w)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic quad_t transform_vertex(input quad_t v);
        quad_t  r;
        longint acc;
        longint prod;
        for (int i = 0; i < VL; i++)
        begin
            acc = 0;
            for (int j = 0; j < VL; j++)
            begin
                prod = longint'($signed(v[j])) * longint'(matrix_model[VL * i + j]);
                acc += prod >>> FB;
            end
            if (acc > SAT_HI)
                acc = SAT_HI;
            if (acc < SAT_LO)
                acc = SAT_LO;
            r[i] = acc[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5: return $urandom;
            default: return DW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic quad_t rand_vertex();
        quad_t v;
        for (int j = 0; j < VL; j++)
            v[j] = rand_q();
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            out_stall <= 1'b1;
            if (hold_count == HOLD_LEN - 1)
            begin
                hold_count <= 0;
                hold_req <= 1'b0;
            end
            else
                hold_count <= hold_count + 1;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end
        else if (stall_enable && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            burst_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        quad_t want;
        quad_t got;
        got = {out_w, out_z, out_y, out_x};
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
                report_mismatch("result word arrived with none expected");
            else
            begin
                want = expected_vertices.pop_front();
                for (int i = 0; i < VL; i++)
                    if (got[i] !== want[i])
                        report_mismatch($sformatf("%s got %h expected %h",
                                                  field_names[i], got[i], want[i]));
            end
        end
    end

    task automatic send_word(input vmt_pkg::req_type_t kind, input logic [IW-1:0] idx,
                             input logic signed [DW-1:0] value, input quad_t v);
        int unsigned gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        element_index <= idx;
        element_value <= value;
        vec_x <= v[0];
        vec_y <= v[1];
        vec_z <= v[2];
        vec_w <= v[3];
        do
            @(posedge clk);
        while (in_stall);
        if (kind == vmt_pkg::REQ_LOAD)
            matrix_model[idx] = value;
        else
            expected_vertices.push_back(transform_vertex(v));
    endtask

    task automatic send_load(input logic [IW-1:0] idx, input logic signed [DW-1:0] value);
        send_word(vmt_pkg::REQ_LOAD, idx, value, rand_vertex());
    endtask

    task automatic send_xform(input quad_t v);
        send_word(vmt_pkg::REQ_XFORM, IW'($urandom), $urandom, v);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_identity();
        send_xform({Q_ONE, Q_ONE, Q_ONE, Q_ONE});
        send_xform({DW'(-1), DW'(0), Q_MIN, Q_MAX});
        send_xform({DW'(0), DW'(-1), Q_MAX, Q_MIN});
        wait_drained();
    endtask

    task automatic test_directed();
        send_load(IW'(0), Q_MAX);
        send_load(IW'(15), Q_MIN);
        send_load(IW'(5), DW'(-1));
        send_load(IW'(10), DW'(1));
        send_xform({DW'(1), Q_MIN, DW'(-1), Q_MAX});
        send_xform({DW'(-1), DW'(-1), DW'(-1), DW'(-1)});
        for (int j = 0; j < VL; j++)
            send_load(IW'(j), Q_MAX);
        send_load(IW'(4), Q_MIN);
        send_xform({Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        send_xform({Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        send_xform({Q_MIN, Q_MAX, Q_MIN, Q_MAX});
        send_load(IW'(1), DW'(3));
        send_xform({DW'(-5), DW'(7), DW'(-3), DW'(1)});
        wait_drained();
    endtask

    task automatic test_random_mixed(input int unsigned num_items);
        int unsigned sent;
        int unsigned loads;
        int unsigned xforms;
        int unsigned next_mix;
        sent = 0;
        next_mix = 0;
        while (sent < num_items)
        begin
            if (sent >= next_mix)
            begin
                idle_enable = $urandom_range(0, 3) != 0;
                stall_enable = $urandom_range(0, 3) != 0;
                next_mix = sent + 100;
            end
            loads = ($urandom_range(0, 9) == 0) ? NE : $urandom_range(0, 6);
            xforms = $urandom_range(1, 8);
            for (int k = 0; k < loads; k++)
                send_load((loads == NE) ? IW'(k) : IW'($urandom), rand_q());
            for (int k = 0; k < xforms; k++)
                send_xform(rand_vertex());
            sent += loads + xforms;
        end
    endtask

    task automatic test_drain_pause();
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 20; k++)
                if ($urandom_range(0, 3) == 0)
                    send_load(IW'($urandom), rand_q());
                else
                    send_xform(rand_vertex());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_xform(rand_vertex());
        while (hold_req)
            @(posedge clk);
        wait_drained();
    endtask

    task automatic test_streaming(input int unsigned num_items);
        idle_enable = 1'b0;
        stall_enable = 1'b0;
        for (int k = 0; k < num_items; k++)
            if ($urandom_range(0, 4) == 0)
                send_load(IW'($urandom), rand_q());
            else
                send_xform(rand_vertex());
        wait_drained();
    endtask

    initial
    begin
        for (int e = 0; e < NE; e++)
            matrix_model[e] = (e % (VL + 1) == 0) ? Q_ONE : '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_directed();
        test_random_mixed(1100);
        test_drain_pause();
        test_backpressure();
        test_streaming(200);

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_vertices.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/vmt_pkg.sv
sv/vmt_matrix_store.sv
sv/vmt_mult_array.sv
sv/vmt_accum_sat.sv
sv/vector_matrix_transform_4x4.sv
tb/testbench.sv
